[src/csp_pkg.sv]
// shared types and constants for the cubic b-spline span generator
// no dependencies; used by every module under src
`timescale 1ns / 1ps

package csp_pkg;

  localparam int CoordW = 32;             // q16.16 coordinate
  localparam int CoefW  = 36;             // polynomial coefficients a..d
  localparam int ValW   = 56;             // forward-difference registers
  localparam int SegW   = 6;              // segment count
  localparam int N2W    = 2 * SegW;       // n^2
  localparam int N3W    = 3 * SegW;       // n^3
  localparam int HalfW  = N3W + 2;        // 3 n^3
  localparam int DenW   = N3W + 3;        // 6 n^3
  localparam int QuotW  = 32;             // quotient bits
  localparam int RemW   = DenW + QuotW + 1;
  localparam int CntW   = $clog2(QuotW);

  localparam logic [SegW-1:0] SegmentsReset = SegW'(16);
  localparam logic [CntW-1:0] LastQuotBit   = CntW'(QuotW - 1);

  typedef struct packed {
    logic signed [CoordW-1:0] p1_x;
    logic signed [CoordW-1:0] p1_y;
    logic signed [CoordW-1:0] p1_z;
    logic signed [CoordW-1:0] p2_x;
    logic signed [CoordW-1:0] p2_y;
    logic signed [CoordW-1:0] p2_z;
    logic signed [CoordW-1:0] p3_x;
    logic signed [CoordW-1:0] p3_y;
    logic signed [CoordW-1:0] p3_z;
    logic signed [CoordW-1:0] p4_x;
    logic signed [CoordW-1:0] p4_y;
    logic signed [CoordW-1:0] p4_z;
  } csp_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     last;
  } csp_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_FIN,
    ST_DIV_INIT,
    ST_DIV,
    ST_OUT
  } csp_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic scale;
    logic fin;
    logic div_init;
    logic div_step;
    logic advance;
  } csp_lane_ctl_t;

endpackage

[src/csp_lane.sv]
// one axis: coefficient setup, forward differencing and a radix-2 divider
// depends on csp_pkg
`timescale 1ns / 1ps

module csp_lane (
  input  logic                                  clk,
  input  csp_pkg::csp_lane_ctl_t                ctl,
  input  logic signed [csp_pkg::CoordW-1:0]     p1,
  input  logic signed [csp_pkg::CoordW-1:0]     p2,
  input  logic signed [csp_pkg::CoordW-1:0]     p3,
  input  logic signed [csp_pkg::CoordW-1:0]     p4,
  input  logic        [csp_pkg::SegW-1:0]       n,
  input  logic        [csp_pkg::N2W-1:0]        n2,
  input  logic        [csp_pkg::N3W-1:0]        n3,
  input  logic        [csp_pkg::DenW-1:0]       den,
  input  logic        [csp_pkg::HalfW-1:0]      half,
  output logic signed [csp_pkg::CoordW-1:0]     point
);

  logic signed [csp_pkg::CoefW-1:0] e1, e2, e3, e4;
  logic signed [csp_pkg::CoefW-1:0] ca, cb, cc, cd;
  logic signed [csp_pkg::ValW-1:0]  t1, t2;
  logic signed [csp_pkg::ValW-1:0]  val, fd, sd, td;
  logic signed [csp_pkg::ValW-1:0]  ca_w;
  logic        [csp_pkg::ValW-1:0]  den_sh;
  logic signed [csp_pkg::ValW-1:0]  biased;
  logic        [csp_pkg::RemW-1:0]  rem, dsh;
  logic        [csp_pkg::QuotW-1:0] q;
  logic                             ge;

  assign e1 = csp_pkg::CoefW'(p1);
  assign e2 = csp_pkg::CoefW'(p2);
  assign e3 = csp_pkg::CoefW'(p3);
  assign e4 = csp_pkg::CoefW'(p4);

  assign ca_w   = csp_pkg::ValW'(ca);
  // offset by 2^31 quotients so the divide is unsigned
  assign den_sh = csp_pkg::ValW'({den, {(csp_pkg::QuotW-1){1'b0}}});
  assign biased = val + $signed(den_sh) + $signed(csp_pkg::ValW'(half));
  assign ge     = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ca <= e4 - e1 + (e2 <<< 1) + e2 - (e3 <<< 1) - e3;
      cb <= (e1 <<< 1) + e1 - (e2 <<< 2) - (e2 <<< 1) + (e3 <<< 1) + e3;
      cc <= (e3 <<< 1) + e3 - (e1 <<< 1) - e1;
      cd <= e1 + (e2 <<< 2) + e3;
    end
    if (ctl.mul) begin
      t1 <= csp_pkg::ValW'(cb * $signed({1'b0, n}));
    end
    if (ctl.scale) begin
      t2 <= csp_pkg::ValW'(cc * $signed({1'b0, n2}));
    end
    if (ctl.fin) begin
      val <= csp_pkg::ValW'(cd * $signed({1'b0, n3}));
      fd  <= ca_w + t1 + t2;
      sd  <= (ca_w <<< 2) + (ca_w <<< 1) + (t1 <<< 1);
      td  <= (ca_w <<< 2) + (ca_w <<< 1);
    end
    if (ctl.div_init) begin
      rem <= csp_pkg::RemW'(biased);
      dsh <= csp_pkg::RemW'(den_sh);
    end
    if (ctl.div_step) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      q   <= {q[csp_pkg::QuotW-2:0], ge};
      dsh <= dsh >> 1;
    end
    if (ctl.advance) begin
      val <= val + fd;
      fd  <= fd + sd;
      sd  <= sd + td;
    end
  end

  // remove the 2^31 offset
  assign point = $signed({~q[csp_pkg::QuotW-1], q[csp_pkg::QuotW-2:0]});

endmodule

[src/cubic_bspline_segment_points.sv]
// top level: sequencer, three axis lanes and the merged output register
// depends on csp_pkg and csp_lane
//
//   channel  direction  handshake          payload
//   pts      in         pts_valid/stall    csp_in_t, four control points
//   pt       out        pt_valid/stall     csp_out_t, one curve point
//   cfg      in         cfg_valid/ready    segments, 6 bits
//
// an item runs through setup (load, mul, scale, fin), then, for each of its n + 1
// points, a bias load, 32 quotient bits from the one-bit-per-cycle divider in each
// lane and an output load. one item is in work at a time.
// rst is synchronous; it clears the sequencer, output valid and sets segments to 16.
// a stalled output holds the sequencer in its output step.
`timescale 1ns / 1ps

module cubic_bspline_segment_points (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pts_valid,
  output logic                       pts_stall,
  input  csp_pkg::csp_in_t           pts,
  output logic                       pt_valid,
  input  logic                       pt_stall,
  output csp_pkg::csp_out_t          pt,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [csp_pkg::SegW-1:0]   cfg_data
);

  csp_pkg::csp_state_t    state, state_next;
  csp_pkg::csp_lane_ctl_t ctl;

  logic [csp_pkg::SegW-1:0]  segments, n, k;
  logic [csp_pkg::N2W-1:0]   n2;
  logic [csp_pkg::N3W-1:0]   n3;
  logic [csp_pkg::DenW-1:0]  den;
  logic [csp_pkg::HalfW-1:0] half;
  logic [csp_pkg::CntW-1:0]  cnt;
  logic                      pt_load;
  logic                      at_end;
  logic signed [csp_pkg::CoordW-1:0] x_q, y_q, z_q;

  assign cfg_ready = 1'b1;
  assign at_end    = (k == n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= csp_pkg::ST_IDLE;
      segments <= csp_pkg::SegmentsReset;
      pt_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        segments <= cfg_data;
      end
      if (pt_load) begin
        pt_valid <= 1'b1;
      end else if (!pt_stall) begin
        pt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      n <= (segments == '0) ? csp_pkg::SegW'(1) : segments;
    end
    if (ctl.mul) begin
      n2 <= csp_pkg::N2W'(n * n);
    end
    if (ctl.scale) begin
      n3 <= csp_pkg::N3W'(n2 * n);
    end
    if (ctl.fin) begin
      den  <= csp_pkg::DenW'({n3, 2'b0}) + csp_pkg::DenW'({n3, 1'b0});
      half <= csp_pkg::HalfW'({n3, 1'b0}) + csp_pkg::HalfW'(n3);
      k    <= '0;
    end
    if (ctl.div_init) begin
      cnt <= csp_pkg::LastQuotBit;
    end else if (ctl.div_step) begin
      cnt <= cnt - 1'b1;
    end
    if (pt_load) begin
      pt.out_x <= x_q;
      pt.out_y <= y_q;
      pt.out_z <= z_q;
      pt.last  <= at_end;
      k        <= k + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    pt_load    = 1'b0;
    pts_stall  = (state != csp_pkg::ST_IDLE);
    case (state)
      csp_pkg::ST_IDLE: begin
        if (pts_valid) begin
          ctl.load   = 1'b1;
          state_next = csp_pkg::ST_MUL;
        end
      end
      csp_pkg::ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = csp_pkg::ST_SCALE;
      end
      csp_pkg::ST_SCALE: begin
        ctl.scale  = 1'b1;
        state_next = csp_pkg::ST_FIN;
      end
      csp_pkg::ST_FIN: begin
        ctl.fin    = 1'b1;
        state_next = csp_pkg::ST_DIV_INIT;
      end
      csp_pkg::ST_DIV_INIT: begin
        ctl.div_init = 1'b1;
        state_next   = csp_pkg::ST_DIV;
      end
      csp_pkg::ST_DIV: begin
        ctl.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = csp_pkg::ST_OUT;
        end
      end
      csp_pkg::ST_OUT: begin
        // wait for room in the output register, then step the differences
        if (!pt_valid || !pt_stall) begin
          pt_load     = 1'b1;
          ctl.advance = 1'b1;
          state_next  = at_end ? csp_pkg::ST_IDLE : csp_pkg::ST_DIV_INIT;
        end
      end
      default: begin
        state_next = csp_pkg::ST_IDLE;
      end
    endcase
  end

  csp_lane u_lane_x (
    .clk(clk), .ctl(ctl),
    .p1(pts.p1_x), .p2(pts.p2_x), .p3(pts.p3_x), .p4(pts.p4_x),
    .n(n), .n2(n2), .n3(n3), .den(den), .half(half), .point(x_q)
  );

  csp_lane u_lane_y (
    .clk(clk), .ctl(ctl),
    .p1(pts.p1_y), .p2(pts.p2_y), .p3(pts.p3_y), .p4(pts.p4_y),
    .n(n), .n2(n2), .n3(n3), .den(den), .half(half), .point(y_q)
  );

  csp_lane u_lane_z (
    .clk(clk), .ctl(ctl),
    .p1(pts.p1_z), .p2(pts.p2_z), .p3(pts.p3_z), .p4(pts.p4_z),
    .n(n), .n2(n2), .n3(n3), .den(den), .half(half), .point(z_q)
  );

endmodule

[src/csp_checker.sv]
// port-level checks for cubic_bspline_segment_points, with its bind
// depends on csp_pkg
`timescale 1ns / 1ps

module csp_checker (
  input logic              clk,
  input logic              rst,
  input logic              pts_valid,
  input logic              pts_stall,
  input logic              pt_valid,
  input logic              pt_stall,
  input csp_pkg::csp_out_t pt
);

  // one span at a time: a transfer in closes the input
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (pts_valid && !pts_stall) |=> pts_stall)
    else $error("input open right after a transfer");

  // an idle block can only hold the final point of a span
  a_idle_holds_last: assert property (@(posedge clk) disable iff (rst)
    (!pts_stall && pt_valid) |-> pt.last)
    else $error("idle with a point that is not the last");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (pt_valid && pt_stall) |=> (pt_valid && $stable(pt)))
    else $error("stalled output changed");

endmodule

bind cubic_bspline_segment_points csp_checker u_csp_checker (
  .clk(clk), .rst(rst), .pts_valid(pts_valid), .pts_stall(pts_stall),
  .pt_valid(pt_valid), .pt_stall(pt_stall), .pt(pt)
);

[verif/cubic_bspline_segment_points_tb.sv]
// testbench for the cubic b-spline span generator: directed table, then random spans
// over several segment counts, checked point by point against an exact-rule predictor
// depends on csp_pkg and cubic_bspline_segment_points
`timescale 1ns / 1ps

module cubic_bspline_segment_points_tb;

  localparam int CycleLimit = 1500000;
  localparam int HoldCycles = 3000;
  localparam logic signed [csp_pkg::CoordW-1:0] CoordMax = 32'sh7fffffff;
  localparam logic signed [csp_pkg::CoordW-1:0] CoordMin = 32'sh80000000;

  typedef struct {
    csp_pkg::csp_in_t                pts;
    bit                              flat;       // all control points equal: every point is that value
    logic [csp_pkg::CoordW-1:0]      flat_val;
  } span_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pts_valid = 1'b0;
  logic pts_stall;
  csp_pkg::csp_in_t pts = '0;
  logic pt_valid;
  logic pt_stall = 1'b0;
  csp_pkg::csp_out_t pt;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [csp_pkg::SegW-1:0] cfg_data = '0;

  csp_pkg::csp_out_t point_q[$];
  int seg_now = 16;
  int bad_count = 0;
  int point_count = 0;
  int span_count = 0;
  int cycle_count = 0;
  int hold_start = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  cubic_bspline_segment_points dut (
    .clk(clk), .rst(rst),
    .pts_valid(pts_valid), .pts_stall(pts_stall), .pts(pts),
    .pt_valid(pt_valid), .pt_stall(pt_stall), .pt(pt),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout with %0d points outstanding", $time, point_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: changing stall pattern plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pt_stall <= 1'b0;
    end else if (hold_start != hold_seen) begin
      hold_seen <= hold_start;
      hold_left <= HoldCycles;
      pt_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pt_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: pt_stall <= 1'b0;
        1: pt_stall <= ($urandom_range(0, 9) < 3);
        2: pt_stall <= (cycle_count % 4 == 0);
        default: pt_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // compare each point transfer with the oldest expected point
  always @(posedge clk) begin
    csp_pkg::csp_out_t want;
    if (!rst && pt_valid && !pt_stall) begin
      point_count <= point_count + 1;
      if (point_q.size() == 0) begin
        $display("%0t unexpected point x=%0d y=%0d z=%0d last=%0b", $time,
                 pt.out_x, pt.out_y, pt.out_z, pt.last);
        bad_count <= bad_count + 1;
      end else begin
        want = point_q.pop_front();
        if (pt.out_x !== want.out_x || pt.out_y !== want.out_y ||
            pt.out_z !== want.out_z || pt.last !== want.last) begin
          $display("%0t point mismatch: expected x=%0d y=%0d z=%0d last=%0b", $time,
                   want.out_x, want.out_y, want.out_z, want.last);
          $display("%0t                 actual   x=%0d y=%0d z=%0d last=%0b", $time,
                   pt.out_x, pt.out_y, pt.out_z, pt.last);
          bad_count <= bad_count + 1;
        end
      end
    end
  end

  // exact rule: floor((F(k) + 3n^3) / 6n^3)
  function automatic logic [csp_pkg::CoordW-1:0] curve_coord(longint p1, longint p2,
                                                             longint p3, longint p4,
                                                             longint n, longint k);
    longint ca, cb, cc, cd, num, den, q;
    ca = -p1 + 3 * p2 - 3 * p3 + p4;
    cb = 3 * p1 - 6 * p2 + 3 * p3;
    cc = 3 * p3 - 3 * p1;
    cd = p1 + 4 * p2 + p3;
    den = 6 * n * n * n;
    num = ca * k * k * k + cb * k * k * n + cc * k * n * n + cd * n * n * n + den / 2;
    q = num / den;
    if (num % den < 0) q = q - 1;
    return q[csp_pkg::CoordW-1:0];
  endfunction

  function automatic int span_steps(int seg);
    return (seg < 1) ? 1 : (seg > 63 ? 63 : seg);
  endfunction

  task automatic predict_span(csp_pkg::csp_in_t c);
    csp_pkg::csp_out_t p;
    int n;
    n = span_steps(seg_now);
    for (int k = 0; k <= n; k++) begin
      p.out_x = curve_coord(c.p1_x, c.p2_x, c.p3_x, c.p4_x, n, k);
      p.out_y = curve_coord(c.p1_y, c.p2_y, c.p3_y, c.p4_y, n, k);
      p.out_z = curve_coord(c.p1_z, c.p2_z, c.p3_z, c.p4_z, n, k);
      p.last = (k == n);
      point_q.push_back(p);
    end
  endtask

  task automatic send_span(csp_pkg::csp_in_t c);
    pts <= c;
    pts_valid <= 1'b1;
    span_count++;
    @(posedge clk);
    while (pts_stall) @(posedge clk);
  endtask

  // sender gap: bursts of back-to-back items with random pauses between them
  int burst_left = 0;
  task automatic sender_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      gap = $urandom_range(1, 40);
      pts_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    pts_valid <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_segments(int v);
    drain();
    repeat (20) @(posedge clk);
    cfg_data <= v[csp_pkg::SegW-1:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    seg_now = v;
  endtask

  function automatic logic [csp_pkg::CoordW-1:0] rand_coord(
      int style, logic [csp_pkg::CoordW-1:0] base);
    case (style)
      0: return $urandom;
      1: return csp_pkg::CoordW'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      2: case ($urandom_range(0, 3))
           0: return CoordMax;
           1: return CoordMin;
           2: return '0;
           default: return '1;
         endcase
      default: return base + csp_pkg::CoordW'($urandom_range(0, 32'h0002_0000))
                      - 32'h0001_0000;
    endcase
  endfunction

  function automatic csp_pkg::csp_in_t rand_span();
    csp_pkg::csp_in_t c;
    int style;
    logic [csp_pkg::CoordW-1:0] base;
    style = $urandom_range(0, 3);
    base = $urandom;
    c.p1_x = rand_coord(style, base); c.p1_y = rand_coord(style, base);
    c.p1_z = rand_coord(style, base); c.p2_x = rand_coord(style, base);
    c.p2_y = rand_coord(style, base); c.p2_z = rand_coord(style, base);
    c.p3_x = rand_coord(style, base); c.p3_y = rand_coord(style, base);
    c.p3_z = rand_coord(style, base); c.p4_x = rand_coord(style, base);
    c.p4_y = rand_coord(style, base); c.p4_z = rand_coord(style, base);
    return c;
  endfunction

  function automatic csp_pkg::csp_in_t flat_span(logic [csp_pkg::CoordW-1:0] v);
    return {12{v}};
  endfunction

  function automatic csp_pkg::csp_in_t split_span(logic [csp_pkg::CoordW-1:0] a,
                                                  logic [csp_pkg::CoordW-1:0] b);
    return {a, b, a, b, a, b, a, b, a, b, a, b};
  endfunction

  span_row_t span_table[$];
  int seg_plan[9] = '{0, 1, 2, 63, 3, 5, 16, 7, 4};
  int item_plan[9] = '{60, 60, 60, 12, 50, 50, 20, 40, 26};

  initial begin
    csp_pkg::csp_out_t p;
    csp_pkg::csp_in_t c;
    span_row_t row;
    int n;

    span_table.push_back('{flat_span('0), 1'b1, '0});
    span_table.push_back('{flat_span(CoordMax), 1'b1, CoordMax});
    span_table.push_back('{flat_span(CoordMin), 1'b1, CoordMin});
    span_table.push_back('{flat_span('1), 1'b1, '1});
    span_table.push_back('{flat_span(32'h0001_8000), 1'b1, 32'h0001_8000});
    span_table.push_back('{flat_span(32'haaaa_5555), 1'b1, 32'haaaa_5555});
    span_table.push_back('{split_span(CoordMax, CoordMin), 1'b0, '0});
    span_table.push_back('{split_span(CoordMin, CoordMax), 1'b0, '0});
    span_table.push_back('{{CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax,
                            CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin},
                           1'b0, '0});
    span_table.push_back('{split_span(32'h0000_0001, '0), 1'b0, '0});
    span_table.push_back('{split_span('1, 32'h0000_0002), 1'b0, '0});
    span_table.push_back('{{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                            32'hfffe_0000, 32'h0000_0003, 32'h7000_0000, 32'h8000_0001,
                            32'h0000_ffff, 32'h1234_5678, 32'hedcb_a987, 32'h5555_aaaa},
                           1'b0, '0});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed spans at the reset segment count
    foreach (span_table[i]) begin
      row = span_table[i];
      if (row.flat) begin
        n = span_steps(seg_now);
        for (int k = 0; k <= n; k++) begin
          p.out_x = row.flat_val; p.out_y = row.flat_val; p.out_z = row.flat_val;
          p.last = (k == n);
          point_q.push_back(p);
        end
      end else begin
        predict_span(row.pts);
      end
      send_span(row.pts);
      sender_gap();
    end

    foreach (seg_plan[ph]) begin
      set_segments(seg_plan[ph]);
      for (int i = 0; i < item_plan[ph]; i++) begin
        // long receiver hold-off while the sender keeps offering spans
        if (ph == 1 && i == 10) hold_start++;
        // sender waits for every pending point now and then
        if (i == item_plan[ph] / 2) drain();
        c = rand_span();
        predict_span(c);
        send_span(c);
        sender_gap();
      end
    end

    drain();
    n = 0;
    while (n < 200) begin
      @(posedge clk);
      n++;
    end
    $display("covered %0d spans, %0d points, segment counts 0 1 2 3 4 5 7 16 63",
             span_count, point_count);
    if (bad_count == 0 && point_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
